// ===== src/dual_input_debounce_qualifier_macros.svh =====
// Assertion helpers for the debounce qualifier.
// With ASSERT_OFF defined the macros expand to nothing.
`ifndef DUAL_INPUT_DEBOUNCE_QUALIFIER_MACROS_SVH
`define DUAL_INPUT_DEBOUNCE_QUALIFIER_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define DIQ_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("debounce qualifier assertion failed");

// A condition that must never be true outside reset.
`define DIQ_ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("debounce qualifier forbidden condition seen");

`else

`define DIQ_ASSERT(label, clk, rst, prop)
`define DIQ_ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ===== src/diq_pkg.sv =====
package diq_pkg;

   // Width of the elapsed counters unless the top level overrides it.
   localparam int TIMER_BITS_DEFAULT = 16;

   // Configuration port geometry.
   localparam int CSR_DATA_BITS  = 16;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SWITCH_DEBOUNCE = 2'd0,
      CSR_STATUS_STABLE   = 2'd1
   } csr_index_type;

   // Reset values of the configuration registers.
   localparam logic [CSR_DATA_BITS-1:0] SWITCH_DEBOUNCE_RESET = 16'd50;
   localparam logic [CSR_DATA_BITS-1:0] STATUS_STABLE_RESET   = 16'd500;

   // Control of one deadline timer for one tick.
   typedef struct packed {
      logic advance;
      logic arm;
   } timer_ctl_type;

   // One result beat.
   typedef struct packed {
      logic status_edge_seen;
      logic status_edge_level;
      logic host_went_up;
      logic host_went_down;
      logic switch_turned_on;
      logic switch_turned_off;
   } rsp_type;

endpackage

// ===== src/diq_deadline_timer.sv =====
// Saturating elapsed counter with a pending flag. On each accepted tick the
// counter advances if it was pending, restarts when armed, and reports the
// deadline as due once the elapsed count reaches the threshold.
module diq_deadline_timer #(
   parameter int TIMER_BITS = diq_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  diq_pkg::timer_ctl_type             ctl,
   input  logic [diq_pkg::CSR_DATA_BITS-1:0]  threshold,
   output logic                               due
);

   localparam int CMP_BITS = (TIMER_BITS > diq_pkg::CSR_DATA_BITS) ?
                             TIMER_BITS : diq_pkg::CSR_DATA_BITS;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   logic                  pending_ff, pending_in;
   logic [TIMER_BITS-1:0] elapsed_ff, elapsed_in;
   logic [TIMER_BITS-1:0] advanced;
   logic                  pending_mid;
   logic [TIMER_BITS-1:0] elapsed_mid;

   // Advance a pending count, then apply a restart, then test the deadline.
   always_comb begin
      if (pending_ff && (elapsed_ff != TIMER_MAX)) begin
         advanced = elapsed_ff + 1'b1;
      end else begin
         advanced = elapsed_ff;
      end
      if (ctl.arm) begin
         pending_mid = 1'b1;
         elapsed_mid = '0;
      end else begin
         pending_mid = pending_ff;
         elapsed_mid = advanced;
      end
      due        = pending_mid && (CMP_BITS'(elapsed_mid) >= CMP_BITS'(threshold));
      pending_in = pending_mid && !due;
      elapsed_in = elapsed_mid;
   end

   // The counter moves only on accepted ticks.
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         elapsed_ff <= '0;
      end else if (ctl.advance) begin
         pending_ff <= pending_in;
         elapsed_ff <= elapsed_in;
      end
   end

endmodule

// ===== src/dual_input_debounce_qualifier.sv =====
// Channel | Direction | Ports                                   | Accepted when
// req     | in        | req_valid, req_stall, two pin levels    | req_valid && !req_stall
// rsp     | out       | rsp_valid, rsp_stall, six event flags   | rsp_valid && !rsp_stall
// csr     | in        | csr_write, csr_index, csr_data          | csr_write
//
// One tick beat is taken every cycle unless req_stall is high; its result is registered.
// The whole update for a tick is one compare and one saturating add per pin.
// A two-entry result buffer lets ticks keep flowing while one result waits;
// req_stall rises only when both entries are full.
// Reset clears all pin states and counters at once; no clearing pass is needed.
module dual_input_debounce_qualifier #(
   parameter int TIMER_BITS = diq_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_switch_pressed,
   input  logic                                req_status_up,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_status_edge_seen,
   output logic                                rsp_status_edge_level,
   output logic                                rsp_host_went_up,
   output logic                                rsp_host_went_down,
   output logic                                rsp_switch_turned_on,
   output logic                                rsp_switch_turned_off,
   input  logic                                csr_write,
   input  logic [diq_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [diq_pkg::CSR_DATA_BITS-1:0]   csr_data
);

`include "dual_input_debounce_qualifier_macros.svh"

   logic [diq_pkg::CSR_DATA_BITS-1:0] switch_ticks_ff;
   logic [diq_pkg::CSR_DATA_BITS-1:0] status_ticks_ff;

   logic prev_switch_ff, switch_stable_ff, switch_stable_in;
   logic status_raw_ff, status_stable_ff, status_stable_in;

   logic accept, take;
   logic status_change, pin_event;
   logic switch_due, status_due;
   diq_pkg::timer_ctl_type switch_ctl, status_ctl;
   diq_pkg::rsp_type       result;

   diq_pkg::rsp_type head_ff, skid_ff;
   logic             head_valid_ff, skid_valid_ff;

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         switch_ticks_ff <= diq_pkg::SWITCH_DEBOUNCE_RESET;
         status_ticks_ff <= diq_pkg::STATUS_STABLE_RESET;
      end else if (csr_write) begin
         case (diq_pkg::csr_index_type'(csr_index))
            diq_pkg::CSR_SWITCH_DEBOUNCE: switch_ticks_ff <= csr_data;
            diq_pkg::CSR_STATUS_STABLE:   status_ticks_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign take      = head_valid_ff && !rsp_stall;

   // Pin-change detection and timer control for this tick.
   assign status_change    = (req_status_up != status_raw_ff);
   assign pin_event        = (req_switch_pressed != prev_switch_ff) || status_change;
   assign switch_ctl.advance = accept;
   assign switch_ctl.arm     = pin_event && (req_switch_pressed != switch_stable_ff);
   assign status_ctl.advance = accept;
   assign status_ctl.arm     = status_change;

   diq_deadline_timer #(
      .TIMER_BITS (TIMER_BITS)
   ) u_switch_timer (
      .clock     (clock),
      .reset     (reset),
      .ctl       (switch_ctl),
      .threshold (switch_ticks_ff),
      .due       (switch_due)
   );

   diq_deadline_timer #(
      .TIMER_BITS (TIMER_BITS)
   ) u_status_timer (
      .clock     (clock),
      .reset     (reset),
      .ctl       (status_ctl),
      .threshold (status_ticks_ff),
      .due       (status_due)
   );

   // Resample at the deadline and form the result beat.
   always_comb begin
      result.status_edge_seen  = status_change;
      result.status_edge_level = status_change && req_status_up;
      result.switch_turned_on  = switch_due && (req_switch_pressed != switch_stable_ff)
                                 && req_switch_pressed;
      result.switch_turned_off = switch_due && (req_switch_pressed != switch_stable_ff)
                                 && !req_switch_pressed;
      result.host_went_up      = status_due && (status_stable_ff != req_status_up)
                                 && req_status_up;
      result.host_went_down    = status_due && (status_stable_ff != req_status_up)
                                 && !req_status_up;
      switch_stable_in = switch_due ? req_switch_pressed : switch_stable_ff;
      status_stable_in = status_due ? req_status_up : status_stable_ff;
   end

   // Pin state advances on accepted ticks only.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_switch_ff   <= 1'b0;
         switch_stable_ff <= 1'b0;
         status_raw_ff    <= 1'b0;
         status_stable_ff <= 1'b0;
      end else if (accept) begin
         prev_switch_ff   <= req_switch_pressed;
         switch_stable_ff <= switch_stable_in;
         status_raw_ff    <= req_status_up;
         status_stable_ff <= status_stable_in;
      end
   end

   // Two-entry result buffer: the head drives the port, the skid catches a
   // beat that arrives while the head is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            head_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (!head_valid_ff || take) begin
         head_valid_ff <= accept;
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            head_ff <= skid_ff;
         end
      end else if (!head_valid_ff || take) begin
         if (accept) begin
            head_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid             = head_valid_ff;
   assign rsp_status_edge_seen  = head_ff.status_edge_seen;
   assign rsp_status_edge_level = head_ff.status_edge_level;
   assign rsp_host_went_up      = head_ff.host_went_up;
   assign rsp_host_went_down    = head_ff.host_went_down;
   assign rsp_switch_turned_on  = head_ff.switch_turned_on;
   assign rsp_switch_turned_off = head_ff.switch_turned_off;

   // The skid entry is only ever filled behind a waiting head.
   `DIQ_ASSERT_NEVER(a_skid_without_head, clock, reset, skid_valid_ff && !head_valid_ff)
   // An edge level is reported only together with the edge itself.
   `DIQ_ASSERT_NEVER(a_level_without_edge, clock, reset,
                     rsp_valid && rsp_status_edge_level && !rsp_status_edge_seen)
   // The host cannot commit up and down on one tick.
   `DIQ_ASSERT_NEVER(a_host_up_and_down, clock, reset,
                     rsp_valid && rsp_host_went_up && rsp_host_went_down)
   // A press and a release are never reported on one tick.
   `DIQ_ASSERT_NEVER(a_switch_on_and_off, clock, reset,
                     rsp_valid && rsp_switch_turned_on && rsp_switch_turned_off)
   // An accepted tick always leaves a result waiting in the next cycle.
   `DIQ_ASSERT(a_accept_gives_result, clock, reset, accept |=> head_valid_ff)

endmodule
